[hdl/mjt_pkg.sv]
// Shared widths, constants and payload types of the minimum-jerk trajectory block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mjt_pkg;

  // field widths
  localparam int TW   = 16;           // step index and step count
  localparam int AW   = 32;           // Q16.16 words
  localparam int PW   = 84;           // position polynomial t^3*(6t^2-15tT+10T^2)
  localparam int VW   = 69;           // velocity polynomial 30t^2(t-T)^2
  localparam int CW   = 55;           // acceleration polynomial 60t|2t-T||t-T|
  localparam int DW   = 80;           // T^5
  localparam int D2W  = DW + 1;       // 2*T^5
  localparam int NL   = 8;            // result lanes
  localparam int PCW  = 28;           // polynomial slice per partial product
  localparam int NPC  = PW / PCW;     // slices per polynomial
  localparam int PPW  = PCW + AW;     // partial product width
  localparam int NMW  = PW + AW;      // |A| * P
  localparam int NW   = NMW + 1;      // 2*|A|*P + T^5
  localparam int QW   = 32;           // quotient bits kept

  // polynomial coefficients
  localparam int C6  = 6;
  localparam int C10 = 10;
  localparam int C15 = 15;
  localparam int C30 = 30;
  localparam int C60 = 60;

  localparam logic [TW-1:0] STEPS_RESET = 16'd100;
  localparam logic [QW-1:0] POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] NEG_MAX     = 32'h8000_0000;

  // result lanes
  localparam int LN_INC_X = 0;
  localparam int LN_INC_Y = 1;
  localparam int LN_POS_X = 2;
  localparam int LN_POS_Y = 3;
  localparam int LN_VEL_X = 4;
  localparam int LN_VEL_Y = 5;
  localparam int LN_ACC_X = 6;
  localparam int LN_ACC_Y = 7;

  // polynomial stage output
  typedef struct packed {
    logic [PW-1:0] pinc;
    logic [PW-1:0] pnow;
    logic [VW-1:0] vel;
    logic [CW-1:0] acc;
    logic [DW-1:0] den;
    logic          aneg;
    logic          rng;
    logic [AW-1:0] ax;
    logic [AW-1:0] ay;
  } mjt_poly_t;

  // scaled numerators ready for division
  typedef struct packed {
    logic [NL-1:0][NW-1:0] num;
    logic [NL-1:0]         neg;
    logic [D2W-1:0]        d2;
    logic                  rng;
  } mjt_num_t;

  // final result
  typedef struct packed {
    logic [NL-1:0][QW-1:0] val;
    logic                  rng;
  } mjt_res_t;

endpackage

`default_nettype wire

[hdl/mjt_poly.sv]
// Polynomial pipeline: step index and step count to the four trajectory polynomials
// and T^5, seven register stages. Depends on mjt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mjt_poly import mjt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [TW-1:0]   step_i,
  input  logic [TW-1:0]   steps_i,
  input  logic [AW-1:0]   adj_x_i,
  input  logic [AW-1:0]   adj_y_i,
  output logic            valid_o,
  output mjt_poly_t       poly_o
);

  localparam int NS  = 7;
  localparam int SQW = 2 * TW;        // t^2, T^2, tT
  localparam int D2L = TW + 1;        // |2t-T|
  localparam int TDW = TW + D2L;      // t*|2t-T|
  localparam int IXW = SQW + 6;       // inner sum headroom
  localparam int INW = SQW + 4;       // inner polynomial
  localparam int V1W = SQW + 5;       // 30t^2
  localparam int A1W = TDW + 6;       // 60t|2t-T|
  localparam int T3W = 3 * TW;
  localparam int X1W = INW + TW;
  localparam int X2W = X1W + TW;
  localparam int VAW = V1W + TW;
  localparam int T4W = 4 * TW;

  typedef struct packed {
    logic [TW-1:0] t;
    logic [TW-1:0] tp;
    logic [TW-1:0] tt;
    logic [TW-1:0] dt;
  } op_t;

  typedef struct packed {
    logic          aneg;
    logic          rng;
    logic [AW-1:0] ax;
    logic [AW-1:0] ay;
  } side_t;

  logic [NS-1:0] v_q;

  logic [TW-1:0]  t0_q, tt0_q;
  logic [AW-1:0]  ax0_q, ay0_q;

  op_t            op1_q, op2_q, op3_q, op4_q;
  side_t          sd1_q, sd2_q, sd3_q, sd4_q, sd5_q;

  logic [SQW-1:0] tsq1_q, ttsq1_q, ttt1_q, tpsq1_q, tpt1_q;
  logic [TDW-1:0] td21_q;

  logic [INW-1:0] inn2_q, innp2_q;
  logic [V1W-1:0] v12_q;
  logic [A1W-1:0] a12_q;
  logic [T3W-1:0] t32_q;

  logic [X1W-1:0] x13_q, xp13_q;
  logic [VAW-1:0] va3_q;
  logic [CW-1:0]  ac3_q, ac4_q, ac5_q;
  logic [T4W-1:0] t43_q;

  logic [X2W-1:0] x24_q, xp24_q;
  logic [VW-1:0]  vel4_q, vel5_q;
  logic [DW-1:0]  t54_q, den5_q;

  logic [PW-1:0]  pn5_q, pp5_q;
  mjt_poly_t      poly_q;

  logic [TW-1:0]  tp_c, dt_c;
  logic [D2L-1:0] tw2_c, tx_c, d2_c;

  // previous step, |t-T| and |2t-T|
  always_comb begin
    tp_c  = (t0_q == '0) ? '0 : t0_q - TW'(1);
    dt_c  = (t0_q >= tt0_q) ? t0_q - tt0_q : tt0_q - t0_q;
    tw2_c = {t0_q, 1'b0};
    tx_c  = {1'b0, tt0_q};
    d2_c  = (tw2_c >= tx_c) ? tw2_c - tx_c : tx_c - tw2_c;
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 0: capture request
      t0_q  <= step_i;
      tt0_q <= steps_i;
      ax0_q <= adj_x_i;
      ay0_q <= adj_y_i;

      // stage 1: squares and cross products
      op1_q   <= '{t: t0_q, tp: tp_c, tt: tt0_q, dt: dt_c};
      sd1_q   <= '{aneg: (tw2_c > tx_c) && (t0_q < tt0_q), rng: t0_q > tt0_q,
                   ax: ax0_q, ay: ay0_q};
      tsq1_q  <= SQW'(t0_q) * SQW'(t0_q);
      ttsq1_q <= SQW'(tt0_q) * SQW'(tt0_q);
      ttt1_q  <= SQW'(t0_q) * SQW'(tt0_q);
      tpsq1_q <= SQW'(tp_c) * SQW'(tp_c);
      tpt1_q  <= SQW'(tp_c) * SQW'(tt0_q);
      td21_q  <= TDW'(t0_q) * TDW'(d2_c);

      // stage 2: inner quadratics, coefficient scaling, T^3
      op2_q   <= op1_q;
      sd2_q   <= sd1_q;
      inn2_q  <= INW'(IXW'(tsq1_q) * IXW'(C6) + IXW'(ttsq1_q) * IXW'(C10)
                      - IXW'(ttt1_q) * IXW'(C15));
      innp2_q <= INW'(IXW'(tpsq1_q) * IXW'(C6) + IXW'(ttsq1_q) * IXW'(C10)
                      - IXW'(tpt1_q) * IXW'(C15));
      v12_q   <= V1W'(tsq1_q) * V1W'(C30);
      a12_q   <= A1W'(td21_q) * A1W'(C60);
      t32_q   <= T3W'(ttsq1_q) * T3W'(op1_q.tt);

      // stage 3
      op3_q   <= op2_q;
      sd3_q   <= sd2_q;
      x13_q   <= X1W'(inn2_q) * X1W'(op2_q.t);
      xp13_q  <= X1W'(innp2_q) * X1W'(op2_q.tp);
      va3_q   <= VAW'(v12_q) * VAW'(op2_q.dt);
      ac3_q   <= CW'(a12_q) * CW'(op2_q.dt);
      t43_q   <= T4W'(t32_q) * T4W'(op2_q.tt);

      // stage 4
      op4_q   <= op3_q;
      sd4_q   <= sd3_q;
      x24_q   <= X2W'(x13_q) * X2W'(op3_q.t);
      xp24_q  <= X2W'(xp13_q) * X2W'(op3_q.tp);
      vel4_q  <= VW'(va3_q) * VW'(op3_q.dt);
      ac4_q   <= ac3_q;
      t54_q   <= DW'(t43_q) * DW'(op3_q.tt);

      // stage 5: last factor of t^3
      sd5_q   <= sd4_q;
      pn5_q   <= PW'(x24_q) * PW'(op4_q.t);
      pp5_q   <= PW'(xp24_q) * PW'(op4_q.tp);
      vel5_q  <= vel4_q;
      ac5_q   <= ac4_q;
      den5_q  <= t54_q;

      // stage 6: increment polynomial
      poly_q  <= '{pinc: pn5_q - pp5_q, pnow: pn5_q, vel: vel5_q, acc: ac5_q,
                   den: den5_q, aneg: sd5_q.aneg, rng: sd5_q.rng,
                   ax: sd5_q.ax, ay: sd5_q.ay};
    end
  end

  assign valid_o = v_q[NS-1];
  assign poly_o  = poly_q;

endmodule

`default_nettype wire

[hdl/mjt_scale.sv]
// Scaling pipeline: multiplies each polynomial by the displacement magnitude in
// sliced partial products and forms the rounded-division operands. Depends on mjt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mjt_scale import mjt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  mjt_poly_t  poly_i,
  output logic       valid_o,
  output mjt_num_t   num_o
);

  localparam int NS = 3;

  logic [NS-1:0] v_q;

  logic [NL-1:0][PW-1:0] p_c;
  logic [NL-1:0][AW-1:0] mag_c;
  logic [NL-1:0]         neg_c;
  logic [AW-1:0]         mx_c, my_c;

  logic [NL-1:0][NPC-1:0][PPW-1:0] pp_q;
  logic [NL-1:0]                   neg0_q, neg1_q;
  logic [DW-1:0]                   den0_q, den1_q;
  logic                            rng0_q, rng1_q;
  logic [NL-1:0][NMW-1:0]          n_d, n_q;
  mjt_num_t                        num_q;

  // lane selection: polynomial, magnitude and sign
  always_comb begin
    mx_c = poly_i.ax[AW-1] ? AW'(0) - poly_i.ax : poly_i.ax;
    my_c = poly_i.ay[AW-1] ? AW'(0) - poly_i.ay : poly_i.ay;

    p_c[LN_INC_X] = poly_i.pinc;
    p_c[LN_INC_Y] = poly_i.pinc;
    p_c[LN_POS_X] = poly_i.pnow;
    p_c[LN_POS_Y] = poly_i.pnow;
    p_c[LN_VEL_X] = PW'(poly_i.vel);
    p_c[LN_VEL_Y] = PW'(poly_i.vel);
    p_c[LN_ACC_X] = PW'(poly_i.acc);
    p_c[LN_ACC_Y] = PW'(poly_i.acc);

    for (int l = 0; l < NL; l++) begin
      mag_c[l] = l[0] ? my_c : mx_c;
      neg_c[l] = l[0] ? poly_i.ay[AW-1] : poly_i.ax[AW-1];
    end
    // acceleration changes sign in the second half of the move
    neg_c[LN_ACC_X] = poly_i.ax[AW-1] ^ poly_i.aneg;
    neg_c[LN_ACC_Y] = poly_i.ay[AW-1] ^ poly_i.aneg;
  end

  // partial products summed
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      n_d[l] = '0;
      for (int j = 0; j < NPC; j++) begin
        n_d[l] = n_d[l] + (NMW'(pp_q[l][j]) << (j * PCW));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 0: slice products
      for (int l = 0; l < NL; l++) begin
        for (int j = 0; j < NPC; j++) begin
          pp_q[l][j] <= PPW'(p_c[l][j*PCW +: PCW]) * PPW'(mag_c[l]);
        end
      end
      neg0_q <= neg_c;
      den0_q <= poly_i.den;
      rng0_q <= poly_i.rng;

      // stage 1: full numerators
      n_q    <= n_d;
      neg1_q <= neg0_q;
      den1_q <= den0_q;
      rng1_q <= rng0_q;

      // stage 2: 2n + d over 2d gives round half away from zero
      for (int l = 0; l < NL; l++) begin
        num_q.num[l] <= {n_q[l], 1'b0} + NW'(den1_q);
      end
      num_q.neg <= neg1_q;
      num_q.d2  <= {den1_q, 1'b0};
      num_q.rng <= rng1_q;
    end
  end

  assign valid_o = v_q[NS-1];
  assign num_o   = num_q;

endmodule

`default_nettype wire

[hdl/mjt_div.sv]
// Pipelined restoring divider, eight lanes sharing one divisor: overflow stage,
// one quotient bit per stage, then sign and saturation. Depends on mjt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mjt_div import mjt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  mjt_num_t  num_i,
  output logic      valid_o,
  output mjt_res_t  res_o
);

  localparam int NS = QW + 2;

  logic [NS-1:0] v_q;

  logic [NL-1:0][NW-1:0] rem_q [QW+1];
  logic [NL-1:0][NW-1:0] rem_d [QW+1];
  logic [NL-1:0][QW-1:0] quo_q [QW+1];
  logic [NL-1:0][QW-1:0] quo_d [QW+1];
  logic [NL-1:0]         ovf_q [QW+1];
  logic [NL-1:0]         ovf_d [QW+1];
  logic [NL-1:0]         neg_q [QW+1];
  logic [D2W-1:0]        d2_q  [QW+1];
  logic                  rng_q [QW+1];
  logic [NW-1:0]         sh_c  [QW+1];
  mjt_res_t              res_d, res_q;

  always_comb begin
    // first stage: quotient of 2^32 or more saturates
    sh_c[0]  = NW'(num_i.d2) << QW;
    rem_d[0] = num_i.num;
    quo_d[0] = '0;
    for (int l = 0; l < NL; l++) begin
      ovf_d[0][l] = num_i.num[l] >= sh_c[0];
    end

    // one quotient bit per stage, most significant first
    for (int k = 1; k <= QW; k++) begin
      sh_c[k]  = NW'(d2_q[k-1]) << (QW - k);
      ovf_d[k] = ovf_q[k-1];
      for (int l = 0; l < NL; l++) begin
        if (rem_q[k-1][l] >= sh_c[k]) begin
          rem_d[k][l] = rem_q[k-1][l] - sh_c[k];
          quo_d[k][l] = quo_q[k-1][l] | (QW'(1) << (QW - k));
        end else begin
          rem_d[k][l] = rem_q[k-1][l];
          quo_d[k][l] = quo_q[k-1][l];
        end
      end
    end

    // sign and saturation
    res_d.rng = rng_q[QW];
    for (int l = 0; l < NL; l++) begin
      if (!neg_q[QW][l]) begin
        res_d.val[l] = (ovf_q[QW][l] || quo_q[QW][l] > POS_MAX) ? POS_MAX : quo_q[QW][l];
      end else if (ovf_q[QW][l] || quo_q[QW][l] > NEG_MAX) begin
        res_d.val[l] = NEG_MAX;
      end else begin
        res_d.val[l] = QW'(0) - quo_q[QW][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= QW; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        ovf_q[k] <= ovf_d[k];
      end
      neg_q[0] <= num_i.neg;
      d2_q[0]  <= num_i.d2;
      rng_q[0] <= num_i.rng;
      for (int k = 1; k <= QW; k++) begin
        neg_q[k] <= neg_q[k-1];
        d2_q[k]  <= d2_q[k-1];
        rng_q[k] <= rng_q[k-1];
      end
      res_q <= res_d;
    end
  end

  assign valid_o = v_q[NS-1];
  assign res_o   = res_q;

endmodule

`default_nettype wire

[hdl/min_jerk_trajectory_step_top.sv]
// Minimum-jerk trajectory step evaluator, two axes, Q16.16.
// Uses mjt_pkg, mjt_poly, mjt_scale and mjt_div.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one request per cycle while
//    in_ready_o is high: displacement per axis (adj_x_i, adj_y_i) and the step index (step_i).
//  - Output channel (out_valid_o/out_ready_i) returns one result per request,
//    in order: increment, position, velocity and acceleration per axis, plus
//    range_error_o when the step lies past the programmed duration.
//  - Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes total_steps;
//    always ready. Write it only while no request is in flight. Zero acts as one.
//  - Each request passes through mjt_poly, mjt_scale and mjt_div, then the
//    output register. One request per cycle while in_ready_o is high, set by
//    the fully pipelined divider (one quotient bit per stage, 32 stages) behind
//    the polynomial and scaling stages.
//  - When the receiver stalls, a skid register takes one more result; the
//    whole pipeline then holds and in_ready_o drops until the output drains.
//  - Reset: total_steps returns to 100, the pipeline and output are emptied.
`timescale 1ns / 1ps
`default_nettype none

module min_jerk_trajectory_step_top import mjt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [TW-1:0]        cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [AW-1:0] adj_x_i,
  input  logic signed [AW-1:0] adj_y_i,
  input  logic [TW-1:0]        step_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [AW-1:0] inc_x_o,
  output logic signed [AW-1:0] inc_y_o,
  output logic signed [AW-1:0] pos_x_o,
  output logic signed [AW-1:0] pos_y_o,
  output logic signed [AW-1:0] vel_x_o,
  output logic signed [AW-1:0] vel_y_o,
  output logic signed [AW-1:0] acc_x_o,
  output logic signed [AW-1:0] acc_y_o,
  output logic                 range_error_o
);

  logic [TW-1:0] steps_q;
  logic [TW-1:0] steps_c;
  logic          en;

  logic          poly_v, num_v, res_v;
  mjt_poly_t     poly;
  mjt_num_t      num;
  mjt_res_t      res;

  logic          out_v_q, skid_v_q;
  mjt_res_t      out_q, skid_q;

  // duration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEPS_RESET;
    end else if (cfg_valid_i) begin
      steps_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign steps_c     = (steps_q == '0) ? TW'(1) : steps_q;

  // pipeline runs while the skid register is free
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  mjt_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .step_i  (step_i),
    .steps_i (steps_c),
    .adj_x_i (adj_x_i),
    .adj_y_i (adj_y_i),
    .valid_o (poly_v),
    .poly_o  (poly)
  );

  mjt_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (poly_v),
    .poly_i  (poly),
    .valid_o (num_v),
    .num_o   (num)
  );

  mjt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (num_v),
    .num_i   (num),
    .valid_o (res_v),
    .res_o   (res)
  );

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (res_v) begin
        if (!out_v_q || out_ready_i) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end else if (out_ready_i) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (res_v) begin
        if (!out_v_q || out_ready_i) begin
          out_q <= res;
        end else begin
          skid_q <= res;
        end
      end
    end else if (out_ready_i) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign inc_x_o       = out_q.val[LN_INC_X];
  assign inc_y_o       = out_q.val[LN_INC_Y];
  assign pos_x_o       = out_q.val[LN_POS_X];
  assign pos_y_o       = out_q.val[LN_POS_Y];
  assign vel_x_o       = out_q.val[LN_VEL_X];
  assign vel_y_o       = out_q.val[LN_VEL_Y];
  assign acc_x_o       = out_q.val[LN_ACC_X];
  assign acc_y_o       = out_q.val[LN_ACC_Y];
  assign range_error_o = out_q.rng;

endmodule

`default_nettype wire
